/* src/tcw_pkg.sv */
package tcw_pkg;

  // default screen geometry
  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  // one cell: character in the low byte, style in the high byte
  localparam int unsigned CELL_W = 16;

  // item kinds
  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // interpreted control characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // spaces written by a tab before the extra skip
  localparam logic [2:0] TAB_SPACES = 3'd4;
  localparam logic [2:0] ONE_WRITE  = 3'd1;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PUT,
    S_SCROLL,
    S_SCRL_END,
    S_BS_WR,
    S_BS_CHK,
    S_BS_WAIT,
    S_CLEAR,
    S_READ,
    S_RDATA,
    S_DONE
  } state_e;

endpackage

/* src/tcw_ram.sv */
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/text_console_writer_core.sv */
// text console writer: a cell store of COLUMNS x ROWS characters with a cursor
//
// input channel (s_axis_*): one item per handshake; tuser carries the kind
// (put character, clear screen, read one cell), tdata the character, the two
// color nibbles and the cell index of a read
// output channel (m_axis_*): exactly one result item per input item, in order,
// carrying the cursor after the item, the read cell and a scroll flag
//
// items are handled one at a time by the sequencer around the cell ram: a
// clear sweeps every cell; a put, tab or newline that runs past the last row
// first scrolls the whole store up a row; a backspace writes a space before
// the cursor and then walks back over null cells; the next item is taken as
// soon as the sequencer is idle, even while the last result still waits in
// the output register
//
// reset: the ram is swept to zero, one cell a cycle;
// s_axis_tready stays low until the sweep ends, the cursor sits at cell zero
// a stalled receiver holds the result in the output register; the sequencer
// then waits at its last step and takes no new item until the slot frees
module text_console_writer_core #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // char_code[7:0], fore_color[11:8],
                                       // back_color[15:12], cell_index[26:16]
  input  logic [1:0]  s_axis_tuser_i,  // kind[1:0]
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o   // cursor_at[10:0], cell_char[18:11],
                                       // cell_style[26:19], did_scroll[27]
);

  localparam int unsigned EXTENT = COLUMNS * ROWS;
  localparam int unsigned AW     = $clog2(EXTENT);
  localparam int unsigned CW     = $clog2(COLUMNS);
  localparam int unsigned CELL_W = tcw_pkg::CELL_W;

  localparam logic [AW-1:0] LAST_CELL = AW'(EXTENT - 1);
  localparam logic [AW-1:0] LAST_ROW  = AW'(EXTENT - COLUMNS);
  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
  localparam logic [AW-1:0] ONE_A     = AW'(1);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [CW-1:0] ONE_C     = CW'(1);

  // input fields
  logic [1:0]  in_kind;
  logic [7:0]  in_char;
  logic [3:0]  in_fore;
  logic [3:0]  in_back;
  logic [10:0] in_index;

  assign in_kind  = s_axis_tuser_i;
  assign in_char  = s_axis_tdata_i[7:0];
  assign in_fore  = s_axis_tdata_i[11:8];
  assign in_back  = s_axis_tdata_i[15:12];
  assign in_index = s_axis_tdata_i[26:16];

  // control state
  tcw_pkg::state_e state_q, state_d;
  logic [AW-1:0]   cursor_q, cursor_d;
  logic [CW-1:0]   col_q, col_d;
  logic [AW-1:0]   rowst_q, rowst_d;   // first cell of the cursor row
  logic [AW-1:0]   sweep_q, sweep_d;
  logic [2:0]      wr_left_q, wr_left_d;
  logic            adv_q, adv_d;       // one more advance without write
  logic            scrolled_q, scrolled_d;
  logic            wpend_q, wpend_d;   // scroll copy write, due in the cycle after its read
  logic            out_valid_q, out_valid_d;

  // payload
  logic [7:0]      char_q, char_d;
  logic [7:0]      style_q, style_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic            rd_ok_q, rd_ok_d;
  logic [AW-1:0]   waddr_q, waddr_d;
  logic            wmask_q, wmask_d;
  logic [7:0]      res_char_q, res_char_d;
  logic [7:0]      res_style_q, res_style_d;
  logic [31:0]     out_data_q, out_data_d;

  // ram ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // cursor neighbors
  logic [AW-1:0] cur_inc, rowst_inc, cur_dec, rowst_dec, rowst_next;
  logic [CW-1:0] col_inc, col_dec;

  assign rowst_next = rowst_q + COLS_A;
  assign cur_inc    = cursor_q + ONE_A;
  assign cur_dec    = cursor_q - ONE_A;

  always_comb begin
    if (col_q == COL_LAST) begin
      col_inc   = '0;
      rowst_inc = rowst_next;
    end else begin
      col_inc   = col_q + ONE_C;
      rowst_inc = rowst_q;
    end
    if (col_q == '0) begin
      col_dec   = COL_LAST;
      rowst_dec = rowst_q - COLS_A;
    end else begin
      col_dec   = col_q - ONE_C;
      rowst_dec = rowst_q;
    end
  end

  logic in_fire;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == tcw_pkg::S_IDLE);

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    col_d       = col_q;
    rowst_d     = rowst_q;
    sweep_d     = sweep_q;
    wr_left_d   = wr_left_q;
    adv_d       = adv_q;
    scrolled_d  = scrolled_q;
    wpend_d     = 1'b0;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    style_d     = style_q;
    idx_d       = idx_q;
    rd_ok_d     = rd_ok_q;
    waddr_d     = waddr_q;
    wmask_d     = wmask_q;
    res_char_d  = res_char_q;
    res_style_d = res_style_q;
    out_data_d  = out_data_q;

    ram_we    = 1'b0;
    ram_waddr = cursor_q;
    ram_wdata = {style_q, char_q};
    ram_raddr = cur_dec;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    // scroll copy lands in the cycle after its read
    if (wpend_q) begin
      ram_we    = 1'b1;
      ram_waddr = waddr_q;
      ram_wdata = wmask_q ? {ram_rdata[CELL_W-1:8], tcw_pkg::CH_NUL} : ram_rdata;
    end

    case (state_q)
      tcw_pkg::S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = '0;
        sweep_d   = sweep_q + ONE_A;
        if (sweep_q == LAST_CELL) begin
          state_d = tcw_pkg::S_IDLE;
        end
      end

      tcw_pkg::S_IDLE: begin
        if (in_fire) begin
          style_d     = {in_back, in_fore};
          char_d      = in_char;
          idx_d       = AW'(in_index);
          rd_ok_d     = (32'(in_index) < 32'(EXTENT));
          scrolled_d  = 1'b0;
          res_char_d  = '0;
          res_style_d = '0;
          sweep_d     = '0;
          wr_left_d   = '0;
          adv_d       = 1'b0;
          case (in_kind)
            tcw_pkg::KIND_PUT: begin
              case (in_char)
                tcw_pkg::CH_NL: begin
                  if (rowst_q == LAST_ROW) begin
                    state_d = tcw_pkg::S_SCROLL;
                  end else begin
                    cursor_d = rowst_next;
                    rowst_d  = rowst_next;
                    col_d    = '0;
                    state_d  = tcw_pkg::S_DONE;
                  end
                end
                tcw_pkg::CH_CR: begin
                  cursor_d = rowst_q;
                  col_d    = '0;
                  state_d  = tcw_pkg::S_DONE;
                end
                tcw_pkg::CH_TAB: begin
                  char_d    = tcw_pkg::CH_SPACE;
                  wr_left_d = tcw_pkg::TAB_SPACES;
                  adv_d     = 1'b1;
                  state_d   = tcw_pkg::S_PUT;
                end
                tcw_pkg::CH_BS: begin
                  state_d = tcw_pkg::S_BS_WR;
                end
                default: begin
                  wr_left_d = tcw_pkg::ONE_WRITE;
                  state_d   = tcw_pkg::S_PUT;
                end
              endcase
            end
            tcw_pkg::KIND_CLEAR: state_d = tcw_pkg::S_CLEAR;
            tcw_pkg::KIND_READ:  state_d = tcw_pkg::S_READ;
            default:             state_d = tcw_pkg::S_DONE;
          endcase
        end
      end

      // write at the cursor and/or advance, one step a cycle
      tcw_pkg::S_PUT: begin
        if ((wr_left_q != '0) || adv_q) begin
          if (wr_left_q != '0) begin
            ram_we    = 1'b1;
            ram_waddr = cursor_q;
            ram_wdata = {style_q, char_q};
            wr_left_d = wr_left_q - 3'd1;
          end else begin
            adv_d = 1'b0;
          end
          if (cursor_q == LAST_CELL) begin
            sweep_d = '0;
            state_d = tcw_pkg::S_SCROLL;
          end else begin
            cursor_d = cur_inc;
            col_d    = col_inc;
            rowst_d  = rowst_inc;
          end
        end else begin
          state_d = tcw_pkg::S_DONE;
        end
      end

      // copy each row up; the last row rereads itself with chars dropped
      tcw_pkg::S_SCROLL: begin
        ram_raddr = (sweep_q < LAST_ROW) ? (sweep_q + COLS_A) : sweep_q;
        wpend_d   = 1'b1;
        waddr_d   = sweep_q;
        wmask_d   = (sweep_q >= LAST_ROW);
        sweep_d   = sweep_q + ONE_A;
        if (sweep_q == LAST_CELL) begin
          state_d = tcw_pkg::S_SCRL_END;
        end
      end

      tcw_pkg::S_SCRL_END: begin
        cursor_d   = LAST_ROW;
        rowst_d    = LAST_ROW;
        col_d      = '0;
        scrolled_d = 1'b1;
        state_d    = tcw_pkg::S_PUT;
      end

      tcw_pkg::S_BS_WR: begin
        if (cursor_q == '0) begin
          state_d = tcw_pkg::S_DONE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = cur_dec;
          ram_wdata = {style_q, tcw_pkg::CH_SPACE};
          cursor_d  = cur_dec;
          col_d     = col_dec;
          rowst_d   = rowst_dec;
          state_d   = tcw_pkg::S_BS_CHK;
        end
      end

      tcw_pkg::S_BS_CHK: begin
        ram_raddr = cur_dec;
        if (cursor_q == '0) begin
          state_d = tcw_pkg::S_DONE;
        end else begin
          state_d = tcw_pkg::S_BS_WAIT;
        end
      end

      tcw_pkg::S_BS_WAIT: begin
        if (ram_rdata[7:0] == tcw_pkg::CH_NUL) begin
          cursor_d = cur_dec;
          col_d    = col_dec;
          rowst_d  = rowst_dec;
          state_d  = tcw_pkg::S_BS_CHK;
        end else begin
          state_d = tcw_pkg::S_DONE;
        end
      end

      tcw_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = {style_q, tcw_pkg::CH_NUL};
        sweep_d   = sweep_q + ONE_A;
        if (sweep_q == LAST_CELL) begin
          state_d = tcw_pkg::S_DONE;
        end
      end

      tcw_pkg::S_READ: begin
        ram_raddr = idx_q;
        state_d   = tcw_pkg::S_RDATA;
      end

      tcw_pkg::S_RDATA: begin
        if (rd_ok_q) begin
          res_char_d  = ram_rdata[7:0];
          res_style_d = ram_rdata[CELL_W-1:8];
        end
        state_d = tcw_pkg::S_DONE;
      end

      // hand the result to the output register once it is free
      tcw_pkg::S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {4'b0, scrolled_q, res_style_q, res_char_q, 11'(cursor_q)};
          state_d     = tcw_pkg::S_IDLE;
        end
      end

      default: state_d = tcw_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::S_INIT;
      cursor_q    <= '0;
      col_q       <= '0;
      rowst_q     <= '0;
      sweep_q     <= '0;
      wr_left_q   <= '0;
      adv_q       <= 1'b0;
      scrolled_q  <= 1'b0;
      wpend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      col_q       <= col_d;
      rowst_q     <= rowst_d;
      sweep_q     <= sweep_d;
      wr_left_q   <= wr_left_d;
      adv_q       <= adv_d;
      scrolled_q  <= scrolled_d;
      wpend_q     <= wpend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q      <= char_d;
    style_q     <= style_d;
    idx_q       <= idx_d;
    rd_ok_q     <= rd_ok_d;
    waddr_q     <= waddr_d;
    wmask_q     <= wmask_d;
    res_char_q  <= res_char_d;
    res_style_q <= res_style_d;
    out_data_q  <= out_data_d;
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (EXTENT)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
